// ----- rtl/zfe_pkg.sv -----
// ----------------------------------------------------------------------------
// Z-function engine package
// Shared beat layouts, sequencer states and buffer control types.
// ----------------------------------------------------------------------------
`default_nettype none

package zfe_pkg;

	// Field widths fixed by the channel formats.
	localparam int POS_W  = 6;
	localparam int CNT_W  = 7;
	localparam int BYTE_W = 8;

	typedef logic [CNT_W-1:0] cnt_t;

	// One input beat: a string byte and the end-of-string mark.
	typedef struct packed {
		logic [BYTE_W-1:0] char_byte;
		logic              is_last;
	} in_beat_t;

	// One result beat: position, its Z value and run flags.
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] match_len;
		logic             truncated;
		logic             last_result;
	} out_beat_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ZINIT,
		ST_ZFETCH,
		ST_ZSTART,
		ST_CRD,
		ST_CEV,
		ST_ZWRITE,
		ST_ORD,
		ST_OSHOW
	} zfe_state_t;

	// Control bundle for the character buffer.
	typedef struct packed {
		logic              wr_en;
		cnt_t              wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic              rd_en;
		cnt_t              rd_addr_a;
		cnt_t              rd_addr_b;
	} zfe_buf_req_t;

endpackage

`default_nettype wire

// ----- rtl/zfe_stream_if.sv -----
// ----------------------------------------------------------------------------
// Z-function engine stream channel
// Valid/ready handshake carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface zfe_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/z_function_engine.sv -----
// ----------------------------------------------------------------------------
// Z-function engine
// Loads a byte string and streams its Z-array, one result per position.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on in_ch, one per beat; the beat with is_last set ends
// the string. Up to MAX_LEN bytes are kept; further bytes, a last one too,
// are dropped and every result of that run then carries truncated.
// Loading holds in_ch ready. After the last byte in_ch is not ready while
// the Z pass runs: a setup step, then for each position a fetch of the
// earlier Z value, a start step, a read and a compare step per character
// comparison, a read step with no compare when the matching runs to the end
// of the string (about 2n comparisons over the string), and the Z write, all
// on one shared compare unit fed by a two-port byte buffer. Results then
// leave on out_ch in increasing position order, each read from the Z store
// and then shown; a stalled receiver simply holds the current result.
// position 0 always reports match_len 0 and the final result carries
// last_result. After it is taken the block returns to loading. Reset (arst_n
// low) clears the sequencer, byte count and flags; buffer contents are not
// cleared since only bytes of the current run are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module z_function_engine #(
	parameter int MAX_LEN = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	zfe_stream_if.sink   in_ch,
	zfe_stream_if.source out_ch
);

	localparam int AW = $clog2(MAX_LEN);
	localparam zfe_pkg::cnt_t MAX_CNT = zfe_pkg::CNT_W'(MAX_LEN);
	localparam zfe_pkg::cnt_t ONE     = zfe_pkg::CNT_W'(1);

	zfe_pkg::zfe_state_t state_q, state_d;

	zfe_pkg::cnt_t load_cnt_q;
	logic          ovf_q;
	zfe_pkg::cnt_t i_q, z_q, l_q, r_q, j_q;

	logic [zfe_pkg::POS_W-1:0] z_mem_q [MAX_LEN];
	logic [zfe_pkg::POS_W-1:0] zrd_q;

	zfe_pkg::zfe_buf_req_t      buf_req;
	logic [zfe_pkg::BYTE_W-1:0] byte_a, byte_b;

	zfe_pkg::in_beat_t in_beat;

	logic          in_acc;
	logic          z_rd_en;
	zfe_pkg::cnt_t z_rd_addr;
	logic          z_wr_en;
	logic          in_window;
	zfe_pkg::cnt_t span, prev, z_start, ext;
	logic          suffix_left;
	logic          last_out;

	assign in_beat = in_ch.data;
	assign in_acc  = in_ch.valid && in_ch.ready;

	// Window arithmetic used by the shared compare unit.
	assign in_window   = (i_q <= r_q);
	assign span        = r_q - i_q + ONE;
	assign prev        = {1'b0, zrd_q};
	assign z_start     = in_window ? ((span < prev) ? span : prev) : '0;
	assign ext         = i_q + z_q - ONE;
	assign suffix_left = ((i_q + z_q) < load_cnt_q);
	assign last_out    = ((j_q + ONE) == load_cnt_q);

	zfe_char_buf #(
		.DEPTH(MAX_LEN)
	) u_char_buf (
		.clk         (clk),
		.req         (buf_req),
		.rd_data_a_q (byte_a),
		.rd_data_b_q (byte_b)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			zfe_pkg::ST_LOAD: begin
				if (in_acc && in_beat.is_last) begin
					state_d = zfe_pkg::ST_ZINIT;
				end
			end
			zfe_pkg::ST_ZINIT: begin
				state_d = (load_cnt_q > ONE) ? zfe_pkg::ST_ZFETCH : zfe_pkg::ST_ORD;
			end
			zfe_pkg::ST_ZFETCH: state_d = zfe_pkg::ST_ZSTART;
			zfe_pkg::ST_ZSTART: state_d = zfe_pkg::ST_CRD;
			zfe_pkg::ST_CRD: begin
				state_d = suffix_left ? zfe_pkg::ST_CEV : zfe_pkg::ST_ZWRITE;
			end
			zfe_pkg::ST_CEV: begin
				state_d = (byte_a == byte_b) ? zfe_pkg::ST_CRD : zfe_pkg::ST_ZWRITE;
			end
			zfe_pkg::ST_ZWRITE: begin
				state_d = ((i_q + ONE) < load_cnt_q) ? zfe_pkg::ST_ZFETCH : zfe_pkg::ST_ORD;
			end
			zfe_pkg::ST_ORD: state_d = zfe_pkg::ST_OSHOW;
			zfe_pkg::ST_OSHOW: begin
				if (out_ch.ready) begin
					state_d = last_out ? zfe_pkg::ST_LOAD : zfe_pkg::ST_ORD;
				end
			end
			default: state_d = zfe_pkg::ST_LOAD;
		endcase
	end

	// Output and memory control decoded from the state.
	always_comb begin
		in_ch.ready       = 1'b0;
		out_ch.valid      = 1'b0;
		buf_req.wr_en     = 1'b0;
		buf_req.wr_addr   = load_cnt_q;
		buf_req.wr_data   = in_beat.char_byte;
		buf_req.rd_en     = 1'b0;
		buf_req.rd_addr_a = z_q;
		buf_req.rd_addr_b = i_q + z_q;
		z_rd_en           = 1'b0;
		z_rd_addr         = j_q;
		z_wr_en           = 1'b0;
		case (state_q)
			zfe_pkg::ST_LOAD: begin
				in_ch.ready   = 1'b1;
				buf_req.wr_en = in_ch.valid && (load_cnt_q < MAX_CNT);
			end
			zfe_pkg::ST_ZFETCH: begin
				z_rd_en   = 1'b1;
				z_rd_addr = i_q - l_q;
			end
			zfe_pkg::ST_CRD:    buf_req.rd_en = suffix_left;
			zfe_pkg::ST_ZWRITE: z_wr_en = 1'b1;
			zfe_pkg::ST_ORD:    z_rd_en = 1'b1;
			zfe_pkg::ST_OSHOW:  out_ch.valid = 1'b1;
			default: begin
			end
		endcase
	end

	// Result payload straight from registers.
	always_comb begin
		out_ch.data.position    = j_q[zfe_pkg::POS_W-1:0];
		out_ch.data.match_len   = (j_q == '0) ? '0 : zrd_q;
		out_ch.data.truncated   = ovf_q;
		out_ch.data.last_result = last_out;
	end

	// Z value store: one write per position, one registered read.
	always_ff @(posedge clk) begin
		if (z_wr_en) begin
			z_mem_q[i_q[AW-1:0]] <= z_q[zfe_pkg::POS_W-1:0];
		end
		if (z_rd_en) begin
			zrd_q <= z_mem_q[z_rd_addr[AW-1:0]];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zfe_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Counters, window and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			ovf_q      <= 1'b0;
			i_q        <= '0;
			z_q        <= '0;
			l_q        <= '0;
			r_q        <= '0;
			j_q        <= '0;
		end else begin
			case (state_q)
				zfe_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (load_cnt_q < MAX_CNT) begin
							load_cnt_q <= load_cnt_q + ONE;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				zfe_pkg::ST_ZINIT: begin
					i_q <= ONE;
					l_q <= '0;
					r_q <= '0;
					j_q <= '0;
				end
				zfe_pkg::ST_ZSTART: z_q <= z_start;
				zfe_pkg::ST_CEV: begin
					if (byte_a == byte_b) begin
						z_q <= z_q + ONE;
					end
				end
				zfe_pkg::ST_ZWRITE: begin
					if (ext > r_q) begin
						l_q <= i_q;
						r_q <= ext;
					end
					i_q <= i_q + ONE;
					j_q <= '0;
				end
				zfe_pkg::ST_OSHOW: begin
					if (out_ch.ready) begin
						if (last_out) begin
							load_cnt_q <= '0;
							ovf_q      <= 1'b0;
							l_q        <= '0;
							r_q        <= '0;
						end else begin
							j_q <= j_q + ONE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/zfe_char_buf.sv -----
// ----------------------------------------------------------------------------
// Z-function engine character buffer
// One write port and two registered read ports over the loaded string.
// ----------------------------------------------------------------------------
`default_nettype none

module zfe_char_buf #(
	parameter int DEPTH = 64
) (
	input  wire                       clk,
	input  wire zfe_pkg::zfe_buf_req_t req,
	output logic [zfe_pkg::BYTE_W-1:0] rd_data_a_q,
	output logic [zfe_pkg::BYTE_W-1:0] rd_data_b_q
);

	localparam int AW = $clog2(DEPTH);

	logic [zfe_pkg::BYTE_W-1:0] mem_q [DEPTH];

	// Write port: one byte per loaded beat.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
	end

	// Two read ports, both registered, for the prefix and suffix bytes.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_a_q <= mem_q[req.rd_addr_a[AW-1:0]];
			rd_data_b_q <= mem_q[req.rd_addr_b[AW-1:0]];
		end
	end

endmodule

`default_nettype wire
